// ----- rtl/imu_serial_frame_parser_defines.svh -----
// Assertion macros for the IMU serial frame parser checker.
// Used by imusfp_checker.sv only; expects signals named clock and reset in scope.
`ifndef IMU_SERIAL_FRAME_PARSER_DEFINES_SVH
`define IMU_SERIAL_FRAME_PARSER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define IMUSFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IMUSFP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/imusfp_pkg.sv -----
// Shared types, constants and the type-byte decoder of the IMU frame parser.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package imusfp_pkg;

   localparam int BYTE_W    = 8;
   localparam int VALUE_W   = 16;
   localparam int POS_W     = 4;
   localparam int PAYLOAD_N = 8;
   localparam int IDX_W     = $clog2(PAYLOAD_N);

   localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h55;
   localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;
   localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
   localparam logic [BYTE_W-1:0] TYPE_RATE  = 8'h52;
   localparam logic [BYTE_W-1:0] TYPE_QUAT  = 8'h59;

   // Byte positions within an 11-byte frame.
   localparam logic [POS_W-1:0] POS_TYPE  = 4'd1;
   localparam logic [POS_W-1:0] POS_FIRST = 4'd2;
   localparam logic [POS_W-1:0] POS_CHECK = 4'd10;

   typedef enum logic [1:0] {
      KIND_ANGLE = 2'd0,
      KIND_ACCEL = 2'd1,
      KIND_RATE  = 2'd2,
      KIND_QUAT  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_HUNT = 3'b001,
      ST_TYPE = 3'b010,
      ST_BODY = 3'b100
   } phase_type;

   typedef struct packed {
      logic     known;
      kind_type kind;
   } kind_dec_type;

   typedef struct packed {
      kind_type                   frame_kind;
      logic signed [VALUE_W-1:0]  value_a;
      logic signed [VALUE_W-1:0]  value_b;
      logic signed [VALUE_W-1:0]  value_c;
      logic signed [VALUE_W-1:0]  value_d;
   } result_type;

   // Handshake between parser and result register.
   typedef struct packed {
      logic step;   // parser consumes the staged byte this cycle
      logic emit;   // that byte closes a frame with a good sum
   } parse_ctl_type;

   function automatic kind_dec_type decode_type(input logic [BYTE_W-1:0] b);
      kind_dec_type d;
      d.known = 1'b1;
      d.kind  = KIND_ANGLE;
      case (b)
         TYPE_ANGLE: d.kind = KIND_ANGLE;
         TYPE_ACCEL: d.kind = KIND_ACCEL;
         TYPE_RATE:  d.kind = KIND_RATE;
         TYPE_QUAT:  d.kind = KIND_QUAT;
         default:    d.known = 1'b0;
      endcase
      return d;
   endfunction

endpackage

// ----- rtl/imusfp_req_if.sv -----
// Byte input channel of the IMU frame parser: valid, ready, rx_byte.
// Depends on imusfp_pkg.
`timescale 1ns / 1ps

interface imusfp_req_if import imusfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/imusfp_rsp_if.sv -----
// Result channel of the IMU frame parser: valid, ready, kind and four raw words.
// Depends on imusfp_pkg.
`timescale 1ns / 1ps

interface imusfp_rsp_if import imusfp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   kind_type                  frame_kind;
   logic signed [VALUE_W-1:0] value_a;
   logic signed [VALUE_W-1:0] value_b;
   logic signed [VALUE_W-1:0] value_c;
   logic signed [VALUE_W-1:0] value_d;

   modport source (output valid, output frame_kind, output value_a, output value_b,
                   output value_c, output value_d, input ready);
   modport sink   (input valid, input frame_kind, input value_a, input value_b,
                   input value_c, input value_d, output ready);
endinterface

// ----- rtl/imusfp_in_stage.sv -----
// Input register of the IMU frame parser: holds one received byte.
// Depends on imusfp_pkg.
`timescale 1ns / 1ps

module imusfp_in_stage import imusfp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [BYTE_W-1:0] in_byte,
   output logic              in_ready,
   output logic              stg_valid,
   output logic [BYTE_W-1:0] stg_byte,
   input  logic              stg_take
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;

   assign in_ready = !valid_ff || stg_take;
   assign valid_in = (valid_ff && !stg_take) || (in_valid && in_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
   end

   assign stg_valid = valid_ff;
   assign stg_byte  = byte_ff;

endmodule

// ----- rtl/imusfp_parser.sv -----
// Frame tracker: header hunt, type decode, running sum and payload bytes.
// Depends on imusfp_pkg.
`timescale 1ns / 1ps

module imusfp_parser import imusfp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   output logic              emit,
   output result_type        result
);

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   kind_type          kind_ff, kind_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] store_ff [PAYLOAD_N];
   logic [BYTE_W-1:0] store_in;
   logic              store_we;
   logic [IDX_W-1:0]  store_idx;
   logic [POS_W-1:0]  pos_off;
   logic [BYTE_W-1:0] byte_sum;
   kind_dec_type      dec;

   assign byte_sum  = sum_ff + rx_byte;
   assign dec       = decode_type(rx_byte);
   assign pos_off   = pos_ff - POS_FIRST;
   assign store_idx = pos_off[IDX_W-1:0];
   assign store_in  = rx_byte;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      sum_in   = sum_ff;
      store_we = 1'b0;
      emit     = 1'b0;
      if (step) begin
         case (phase_ff)
            ST_TYPE: begin
               if (dec.known) begin
                  kind_in  = dec.kind;
                  phase_in = ST_BODY;
                  pos_in   = POS_FIRST;
                  sum_in   = byte_sum;
               end else begin
                  // unknown type byte is looked at again as a header
                  kind_in = KIND_ANGLE;
                  if (rx_byte == HDR_BYTE) begin
                     phase_in = ST_TYPE;
                     pos_in   = POS_TYPE;
                     sum_in   = HDR_BYTE;
                  end else begin
                     phase_in = ST_HUNT;
                     pos_in   = '0;
                     sum_in   = '0;
                  end
               end
            end
            ST_BODY: begin
               if (pos_ff < POS_CHECK) begin
                  store_we = 1'b1;
                  sum_in   = byte_sum;
                  pos_in   = pos_ff + 4'd1;
               end else begin
                  emit     = (sum_ff == rx_byte);
                  phase_in = ST_HUNT;
                  pos_in   = '0;
                  kind_in  = KIND_ANGLE;
                  sum_in   = '0;
               end
            end
            default: begin
               if (rx_byte == HDR_BYTE) begin
                  phase_in = ST_TYPE;
                  pos_in   = POS_TYPE;
                  sum_in   = HDR_BYTE;
               end else begin
                  phase_in = ST_HUNT;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_HUNT;
         pos_ff   <= '0;
         kind_ff  <= KIND_ANGLE;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= store_in;
      end
   end

   // little-endian words from frame bytes 2..9
   always_comb begin
      result.frame_kind = kind_ff;
      result.value_a    = {store_ff[1], store_ff[0]};
      result.value_b    = {store_ff[3], store_ff[2]};
      result.value_c    = {store_ff[5], store_ff[4]};
      result.value_d    = (kind_ff == KIND_QUAT) ? {store_ff[7], store_ff[6]} : '0;
   end

endmodule

// ----- rtl/imusfp_out_stage.sv -----
// Result register of the IMU frame parser, drives the result channel.
// Depends on imusfp_pkg.
`timescale 1ns / 1ps

module imusfp_out_stage import imusfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/imu_serial_frame_parser.sv -----
// Top level of the IMU serial frame parser: input register, frame tracker, result register.
// Depends on imusfp_pkg, imusfp_req_if, imusfp_rsp_if and the three stage modules.
//
//   channel   dir  fields                                  item
//   req_chan  in   rx_byte[7:0]                            one received byte
//   rsp_chan  out  frame_kind[1:0], value_a..value_d s16   one good frame
//
// One byte per cycle while the result side does not stall; the running sum and frame position advance once per byte.
// A closing byte passes through the input register and then the result register before it shows as a result.
// Synchronous active-high reset returns to header hunt; payload bytes are not cleared.
// A stalled result holds the parser; the input register still takes one more byte.
// req_chan.ready follows rsp_chan.ready combinationally when both registers are full.
`timescale 1ns / 1ps

module imu_serial_frame_parser import imusfp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   imusfp_req_if.sink     req_chan,
   imusfp_rsp_if.source   rsp_chan
);

   logic              stg_valid;
   logic [BYTE_W-1:0] stg_byte;
   logic              can_load;
   parse_ctl_type     ctl;
   result_type        parse_result;
   result_type        rsp_data;

   // staged byte moves on only when the result register has room
   assign ctl.step = stg_valid && can_load;

   imusfp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_byte   (req_chan.rx_byte),
      .in_ready  (req_chan.ready),
      .stg_valid (stg_valid),
      .stg_byte  (stg_byte),
      .stg_take  (ctl.step)
   );

   imusfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (ctl.step),
      .rx_byte (stg_byte),
      .emit    (ctl.emit),
      .result  (parse_result)
   );

   // bad-sum frames never reach the result register
   imusfp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (ctl.step && ctl.emit),
      .load_data (parse_result),
      .can_load  (can_load),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.frame_kind = rsp_data.frame_kind;
   assign rsp_chan.value_a    = rsp_data.value_a;
   assign rsp_chan.value_b    = rsp_data.value_b;
   assign rsp_chan.value_c    = rsp_data.value_c;
   assign rsp_chan.value_d    = rsp_data.value_d;

endmodule

// ----- rtl/imusfp_checker.sv -----
// Port-level checks for the IMU serial frame parser, bound to the top level.
// Depends on imusfp_pkg and imu_serial_frame_parser_defines.svh.
`timescale 1ns / 1ps
`include "imu_serial_frame_parser_defines.svh"

module imusfp_checker import imusfp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input kind_type                  rsp_frame_kind,
   input logic signed [VALUE_W-1:0] rsp_value_a,
   input logic signed [VALUE_W-1:0] rsp_value_d
);

   `IMUSFP_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")

   `IMUSFP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_kind) && $stable(rsp_value_a), "stalled result changed")

   `IMUSFP_ASSERT(a_value_d_zero, rsp_valid && (rsp_frame_kind != KIND_QUAT) |-> rsp_value_d == '0, "value_d nonzero on non-quaternion frame")

   `IMUSFP_ASSERT_ALWAYS(a_ready_flows, rsp_ready |-> req_ready, "input stalled while result side ready")

endmodule

bind imu_serial_frame_parser imusfp_checker u_imusfp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_frame_kind (rsp_chan.frame_kind),
   .rsp_value_a    (rsp_chan.value_a),
   .rsp_value_d    (rsp_chan.value_d)
);
